// ----- rtl/wbsf_pkg.sv -----
// Shared types and constants for the superframe splitter.
// Holds the job record passed from the parser to the emitter and the frame size table.
// No dependencies.
package wbsf_pkg;

    // result kinds
    localparam logic [1:0] KIND_PKT   = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_TS = 2'd0;
    localparam logic [1:0] CFG_TS_STEP  = 2'd1;
    localparam logic [1:0] CFG_LOOP_LIM = 2'd2;

    localparam int CFG_WIDTH = 33;

    // header checks
    localparam logic [6:0] FT_MAX  = 7'd47;
    localparam logic [4:0] ISF_MAX = 5'd13;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_DATA
    } t_phase;

    // marker/error: 1 result; header pair: 2; payload byte: 1; header pair + payload: 3
    typedef enum logic [1:0] {
        JOB_MARK,
        JOB_HDR,
        JOB_DATA,
        JOB_HDR_DATA
    } t_jtype;

    typedef struct packed {
        t_jtype      jtype;
        logic [1:0]  kind;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [7:0]  data;
        logic        last;
        logic [1:0]  fidx;
        logic [31:0] fnum;
        logic [32:0] ts;
    } t_job;

    function automatic logic [6:0] frame_size(input logic [6:0] ft);
        logic [6:0] sz;
        case (ft)
            7'd0:  sz = 7'd17;  7'd1:  sz = 7'd23;  7'd2:  sz = 7'd32;  7'd3:  sz = 7'd36;
            7'd4:  sz = 7'd40;  7'd5:  sz = 7'd46;  7'd6:  sz = 7'd50;  7'd7:  sz = 7'd58;
            7'd8:  sz = 7'd60;  7'd9:  sz = 7'd5;   7'd10: sz = 7'd34;  7'd11: sz = 7'd45;
            7'd12: sz = 7'd60;  7'd13: sz = 7'd60;  7'd14: sz = 7'd0;   7'd15: sz = 7'd0;
            7'd16: sz = 7'd26;  7'd17: sz = 7'd30;  7'd18: sz = 7'd34;  7'd19: sz = 7'd38;
            7'd20: sz = 7'd42;  7'd21: sz = 7'd48;  7'd22: sz = 7'd52;  7'd23: sz = 7'd60;
            7'd24: sz = 7'd31;  7'd25: sz = 7'd32;  7'd26: sz = 7'd35;  7'd27: sz = 7'd36;
            7'd28: sz = 7'd38;  7'd29: sz = 7'd40;  7'd30: sz = 7'd41;  7'd31: sz = 7'd43;
            7'd32: sz = 7'd45;  7'd33: sz = 7'd46;  7'd34: sz = 7'd48;  7'd35: sz = 7'd50;
            7'd36: sz = 7'd51;  7'd37: sz = 7'd53;  7'd38: sz = 7'd56;  7'd39: sz = 7'd58;
            7'd40: sz = 7'd60;  7'd41: sz = 7'd64;  7'd42: sz = 7'd65;  7'd43: sz = 7'd67;
            7'd44: sz = 7'd72;  7'd45: sz = 7'd74;  7'd46: sz = 7'd75;  7'd47: sz = 7'd80;
            default: sz = 7'd0;
        endcase
        return sz;
    endfunction

endpackage

// ----- rtl/amr_wbplus_superframe_splitter_core.sv -----
// Superframe splitter top: one data word per cycle in, one result word per cycle out, when neither side stalls.
// The first result of a word is written into the job queue, then into the output register.
// Throughput: one word per cycle each way while unstalled; a later frame's header replay adds two output
// words, which the QUEUE_DEPTH job queue soaks up until it fills, then stalls the input.
// Reset (synchronous, active low) clears parser state, counters, queue and output valid.
// Instantiates wbsf_front, wbsf_queue and wbsf_back; uses wbsf_pkg.
module amr_wbplus_superframe_splitter_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_stream_byte,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [wbsf_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_packet_first,
    output logic                           o_packet_last,
    output logic [1:0]                     o_frame_index,
    output logic [31:0]                    o_frame_number,
    output logic [32:0]                    o_timestamp
);

    logic           q_full;
    logic           q_valid;
    logic           push;
    logic           pop;
    wbsf_pkg::t_job push_job;
    wbsf_pkg::t_job head_job;

    assign o_stall = q_full;

    wbsf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_cmd         (i_cmd),
        .i_stream_byte (i_stream_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_full        (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    wbsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    wbsf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (q_valid),
        .i_head         (head_job),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_packet_first (o_packet_first),
        .o_packet_last  (o_packet_last),
        .o_frame_index  (o_frame_index),
        .o_frame_number (o_frame_number),
        .o_timestamp    (o_timestamp)
    );

endmodule

// ----- rtl/wbsf_front.sv -----
// Parser front end: takes stream words, tracks superframe state, counters and
// configuration, and pushes one job per result-producing word. Uses wbsf_pkg.
module wbsf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_cmd,
    input  logic [7:0]                    i_stream_byte,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [wbsf_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_full,
    output logic                          o_push,
    output wbsf_pkg::t_job                o_job
);

    wbsf_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_hdr0, n_hdr0;
    logic [5:0]  r_hdr1, n_hdr1;
    logic [6:0]  r_bytes_left, n_bytes_left;
    logic [6:0]  r_flen, n_flen;
    logic [2:0]  r_frames_left, n_frames_left;
    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_count, n_count;
    logic [32:0] r_time, n_time;
    logic [15:0] r_loops, n_loops;
    logic [15:0] r_step, n_step;
    logic [16:0] r_limit, n_limit;

    logic        accept;
    logic [6:0]  ft;
    logic        hdr_bad;
    logic [6:0]  flen;
    logic        single;
    logic        is_reset;
    logic [32:0] time_adv;
    logic [6:0]  bl_dec;
    logic [2:0]  fl_dec;

    assign accept   = i_valid && !i_full;
    assign ft       = r_hdr0[6:0];
    assign hdr_bad  = (ft > wbsf_pkg::FT_MAX) || (i_stream_byte[4:0] > wbsf_pkg::ISF_MAX);
    assign flen     = wbsf_pkg::frame_size(ft);
    assign single   = ft inside {[7'd0:7'd9], 7'd14, 7'd15};
    assign is_reset = r_limit[16] || ({1'b0, r_loops} < r_limit);
    assign time_adv = r_time + 33'(r_step);
    assign bl_dec   = (r_bytes_left != 7'd0) ? r_bytes_left - 7'd1 : r_bytes_left;
    assign fl_dec   = (r_frames_left != 3'd0) ? r_frames_left - 3'd1 : r_frames_left;

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_hdr0        = r_hdr0;
        n_hdr1        = r_hdr1;
        n_bytes_left  = r_bytes_left;
        n_flen        = r_flen;
        n_frames_left = r_frames_left;
        n_pos         = r_pos;
        n_count       = r_count;
        n_time        = r_time;
        n_loops       = r_loops;
        n_step        = r_step;
        n_limit       = r_limit;

        if (accept) begin
            if (i_cmd) begin
                if (is_reset) begin
                    n_loops = r_loops + 16'd1;
                end
                n_count       = r_count + 32'd1;
                n_time        = time_adv;
                n_phase       = wbsf_pkg::PH_HDR0;
                n_bytes_left  = 7'd0;
                n_frames_left = 3'd0;
                n_pos         = 2'd0;
            end else begin
                case (r_phase)
                    wbsf_pkg::PH_HDR0: begin
                        n_hdr0  = i_stream_byte;
                        n_phase = wbsf_pkg::PH_HDR1;
                    end
                    wbsf_pkg::PH_HDR1: begin
                        n_hdr1  = i_stream_byte[5:0];
                        n_phase = wbsf_pkg::PH_HDR0;
                        if (!hdr_bad) begin
                            n_flen        = flen;
                            n_frames_left = single ? 3'd1 : 3'd4;
                            n_pos         = 2'd0;
                            if (flen == 7'd0) begin
                                n_count       = r_count + 32'd1;
                                n_time        = time_adv;
                                n_frames_left = 3'd0;
                            end else begin
                                n_bytes_left = flen;
                                n_phase      = wbsf_pkg::PH_DATA;
                            end
                        end
                    end
                    wbsf_pkg::PH_DATA: begin
                        n_bytes_left = bl_dec;
                        if (bl_dec == 7'd0) begin
                            // frame done: advance counters, then start the next frame or go back to the header
                            n_count       = r_count + 32'd1;
                            n_time        = time_adv;
                            n_pos         = r_pos + 2'd1;
                            n_frames_left = fl_dec;
                            if (fl_dec == 3'd0) begin
                                n_phase = wbsf_pkg::PH_HDR0;
                                n_pos   = 2'd0;
                            end else begin
                                n_bytes_left = r_flen;
                            end
                        end
                    end
                    default: begin
                        n_phase = wbsf_pkg::PH_HDR0;
                    end
                endcase
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                wbsf_pkg::CFG_START_TS: n_time  = i_cfg_data;
                wbsf_pkg::CFG_TS_STEP:  n_step  = i_cfg_data[15:0];
                wbsf_pkg::CFG_LOOP_LIM: n_limit = i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // job outputs
    always_comb begin
        o_push     = accept && (i_cmd || (r_phase != wbsf_pkg::PH_HDR0));
        o_job.kind = wbsf_pkg::KIND_PKT;
        o_job.hdr0 = r_hdr0;
        o_job.hdr1 = {r_pos, r_hdr1};
        o_job.data = i_stream_byte;
        o_job.last = 1'b0;
        o_job.fidx = 2'd0;
        o_job.fnum = r_count;
        o_job.ts   = r_time;
        o_job.jtype = wbsf_pkg::JOB_MARK;
        if (i_cmd) begin
            o_job.kind = is_reset ? wbsf_pkg::KIND_RESET : wbsf_pkg::KIND_END;
        end else begin
            case (r_phase)
                wbsf_pkg::PH_HDR1: begin
                    if (hdr_bad) begin
                        o_job.kind = wbsf_pkg::KIND_ERR;
                    end else begin
                        o_job.jtype = wbsf_pkg::JOB_HDR;
                        o_job.hdr1  = {2'b00, i_stream_byte[5:0]};
                        o_job.last  = (flen == 7'd0);
                    end
                end
                wbsf_pkg::PH_DATA: begin
                    o_job.fidx  = r_pos;
                    o_job.last  = (r_bytes_left <= 7'd1);
                    o_job.jtype = ((r_bytes_left == r_flen) && (r_pos != 2'd0)) ?
                                  wbsf_pkg::JOB_HDR_DATA : wbsf_pkg::JOB_DATA;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= wbsf_pkg::PH_HDR0;
            r_hdr0        <= 8'd0;
            r_hdr1        <= 6'd0;
            r_bytes_left  <= 7'd0;
            r_flen        <= 7'd0;
            r_frames_left <= 3'd0;
            r_pos         <= 2'd0;
            r_count       <= 32'd0;
            r_time        <= 33'd0;
            r_loops       <= 16'd0;
            r_step        <= 16'd3600;
            r_limit       <= 17'd0;
        end else begin
            r_phase       <= n_phase;
            r_hdr0        <= n_hdr0;
            r_hdr1        <= n_hdr1;
            r_bytes_left  <= n_bytes_left;
            r_flen        <= n_flen;
            r_frames_left <= n_frames_left;
            r_pos         <= n_pos;
            r_count       <= n_count;
            r_time        <= n_time;
            r_loops       <= n_loops;
            r_step        <= n_step;
            r_limit       <= n_limit;
        end
    end

    a_data_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wbsf_pkg::PH_DATA) |-> (r_bytes_left != 7'd0) && (r_frames_left != 3'd0))
        else $error("payload phase with no bytes or frames left");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_left <= 3'd4)
        else $error("frame count out of range");

endmodule

// ----- rtl/wbsf_queue.sv -----
// Short job queue between parser and emitter, register based.
// Uses wbsf_pkg for the job record.
module wbsf_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbsf_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output wbsf_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wbsf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

// ----- rtl/wbsf_back.sv -----
// Emitter back end: expands each queued job into one to three result words
// and holds them in the output register. Uses wbsf_pkg.
module wbsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  wbsf_pkg::t_job i_head,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_packet_first,
    output logic           o_packet_last,
    output logic [1:0]     o_frame_index,
    output logic [31:0]    o_frame_number,
    output logic [32:0]    o_timestamp
);

    logic        r_valid;
    logic [1:0]  r_sub, n_sub;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_first;
    logic        r_last;
    logic [1:0]  r_fidx;
    logic [31:0] r_fnum;
    logic [32:0] r_ts;

    logic        load;
    logic        job_end;
    logic [1:0]  last_sub;
    logic [1:0]  slot;
    logic [7:0]  s_byte;
    logic        s_first;
    logic        s_last;

    assign load = i_head_valid && (!r_valid || !i_stall);

    // pick the word for the current slot of the head job
    always_comb begin
        case (i_head.jtype)
            wbsf_pkg::JOB_HDR:      last_sub = 2'd1;
            wbsf_pkg::JOB_HDR_DATA: last_sub = 2'd2;
            default:                last_sub = 2'd0;
        endcase
        slot    = (i_head.jtype == wbsf_pkg::JOB_DATA) ? 2'd2 : r_sub;
        job_end = (r_sub == last_sub);
        case (slot)
            2'd0:    s_byte = i_head.hdr0;
            2'd1:    s_byte = i_head.hdr1;
            default: s_byte = i_head.data;
        endcase
        s_first = (slot == 2'd0);
        s_last  = job_end && i_head.last;
        if (i_head.jtype == wbsf_pkg::JOB_MARK) begin
            s_byte  = 8'd0;
            s_first = 1'b1;
            s_last  = 1'b1;
        end
        o_pop = load && job_end;
        n_sub = r_sub;
        if (load) begin
            n_sub = job_end ? 2'd0 : r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_head.kind;
            r_byte  <= s_byte;
            r_first <= s_first;
            r_last  <= s_last;
            r_fidx  <= i_head.fidx;
            r_fnum  <= i_head.fnum;
            r_ts    <= i_head.ts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else begin
            r_sub <= n_sub;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_out_byte     = r_byte;
    assign o_packet_first = r_first;
    assign o_packet_last  = r_last;
    assign o_frame_index  = r_fidx;
    assign o_frame_number = r_fnum;
    assign o_timestamp    = r_ts;

    a_mid_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> i_head_valid && (r_sub <= last_sub))
        else $error("job left the queue before all words went out");

endmodule

// ----- tb/wbsf_splitter_checker.sv -----
// Scoreboard for the superframe splitter: follows every accepted input word and config
// write, predicts the packet, marker and error words, and checks the output channel.
// Depends on wbsf_pkg for the result kinds, the register indexes and the parse phases.
module wbsf_splitter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_cmd,
    input  logic [7:0]                     i_stream_byte,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [wbsf_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_packet_first,
    input  logic                           i_packet_last,
    input  logic [1:0]                     i_frame_index,
    input  logic [31:0]                    i_frame_number,
    input  logic [32:0]                    i_timestamp,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] LAST_FT  = 7'd47;
    localparam logic [4:0] LAST_ISF = 5'd13;

    // payload bytes per frame, by frame type
    localparam logic [6:0] FRAME_BYTES [0:47] = '{
        7'd17, 7'd23, 7'd32, 7'd36, 7'd40, 7'd46, 7'd50, 7'd58,
        7'd60, 7'd5,  7'd34, 7'd45, 7'd60, 7'd60, 7'd0,  7'd0,
        7'd26, 7'd30, 7'd34, 7'd38, 7'd42, 7'd48, 7'd52, 7'd60,
        7'd31, 7'd32, 7'd35, 7'd36, 7'd38, 7'd40, 7'd41, 7'd43,
        7'd45, 7'd46, 7'd48, 7'd50, 7'd51, 7'd53, 7'd56, 7'd58,
        7'd60, 7'd64, 7'd65, 7'd67, 7'd72, 7'd74, 7'd75, 7'd80
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        pkt_first;
        logic        pkt_last;
        logic [1:0]  fidx;
        logic [31:0] fnum;
        logic [32:0] ts;
    } t_sf_word;

    t_sf_word    due_words[$];
    int          mismatches = 0;
    int          words_checked = 0;

    logic [32:0] start_ts;
    logic [15:0] ts_step;
    logic [16:0] loop_lim;

    wbsf_pkg::t_phase parse_at;
    logic [7:0]  hdr_a;
    logic [7:0]  hdr_b;
    logic [6:0]  bytes_left;
    logic [6:0]  frame_len;
    logic [2:0]  frames_left;
    logic [1:0]  frame_pos;
    logic [31:0] pkt_count;
    logic [32:0] ts_now;
    logic [15:0] loops_done;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_word(input logic [1:0] kind, input logic [7:0] data,
                              input logic pkt_first, input logic pkt_last,
                              input logic [1:0] fidx);
        t_sf_word w;
        w.kind      = kind;
        w.data      = data;
        w.pkt_first = pkt_first;
        w.pkt_last  = pkt_last;
        w.fidx      = fidx;
        w.fnum      = pkt_count;
        w.ts        = ts_now;
        due_words.insert(due_words.size(), w);
    endtask

    task automatic bump_packet_count();
        pkt_count = pkt_count + 32'd1;
        ts_now    = ts_now + {17'd0, ts_step};
    endtask

    // second header byte with the frame position in the TFI bits
    function automatic logic [7:0] tfi_byte();
        return {frame_pos, hdr_b[5:0]};
    endfunction

    task automatic split_word(input logic cmd, input logic [7:0] b);
        logic [6:0] ft;
        logic [1:0] mark_kind;
        if (cmd) begin
            // replay while loops remain or the limit is negative
            if (loop_lim[16] || loops_done < loop_lim[15:0]) begin
                loops_done = loops_done + 16'd1;
                mark_kind  = wbsf_pkg::KIND_RESET;
            end else begin
                mark_kind = wbsf_pkg::KIND_END;
            end
            queue_word(mark_kind, 8'h00, 1'b1, 1'b1, 2'd0);
            bump_packet_count();
            parse_at    = wbsf_pkg::PH_HDR0;
            bytes_left  = 7'd0;
            frames_left = 3'd0;
            frame_pos   = 2'd0;
        end else begin
            case (parse_at)
                wbsf_pkg::PH_HDR0: begin
                    hdr_a    = b;
                    parse_at = wbsf_pkg::PH_HDR1;
                end
                wbsf_pkg::PH_HDR1: begin
                    ft       = hdr_a[6:0];
                    hdr_b    = b;
                    parse_at = wbsf_pkg::PH_HDR0;
                    if (ft > LAST_FT || b[4:0] > LAST_ISF) begin
                        queue_word(wbsf_pkg::KIND_ERR, 8'h00, 1'b1, 1'b1, 2'd0);
                    end else begin
                        frame_len   = FRAME_BYTES[ft[5:0]];
                        frames_left = (ft <= 7'd9 || ft == 7'd14 || ft == 7'd15) ? 3'd1 : 3'd4;
                        frame_pos   = 2'd0;
                        queue_word(wbsf_pkg::KIND_PKT, hdr_a, 1'b1, 1'b0, 2'd0);
                        if (frame_len == 7'd0) begin
                            queue_word(wbsf_pkg::KIND_PKT, tfi_byte(), 1'b0, 1'b1, 2'd0);
                            bump_packet_count();
                            frames_left = 3'd0;
                        end else begin
                            queue_word(wbsf_pkg::KIND_PKT, tfi_byte(), 1'b0, 1'b0, 2'd0);
                            bytes_left = frame_len;
                            parse_at   = wbsf_pkg::PH_DATA;
                        end
                    end
                end
                default: begin
                    // later frames replay the header ahead of their first payload byte
                    if (bytes_left == frame_len && frame_pos != 2'd0) begin
                        queue_word(wbsf_pkg::KIND_PKT, hdr_a, 1'b1, 1'b0, frame_pos);
                        queue_word(wbsf_pkg::KIND_PKT, tfi_byte(), 1'b0, 1'b0, frame_pos);
                    end
                    queue_word(wbsf_pkg::KIND_PKT, b, 1'b0, bytes_left <= 7'd1, frame_pos);
                    if (bytes_left > 7'd0) bytes_left = bytes_left - 7'd1;
                    if (bytes_left == 7'd0) begin
                        bump_packet_count();
                        frame_pos = frame_pos + 2'd1;
                        if (frames_left > 3'd0) frames_left = frames_left - 3'd1;
                        if (frames_left == 3'd0) begin
                            parse_at  = wbsf_pkg::PH_HDR0;
                            frame_pos = 2'd0;
                        end else begin
                            bytes_left = frame_len;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_word();
        t_sf_word want;
        if (due_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected word kind %0d byte %0h", i_kind, i_out_byte));
            return;
        end
        want = due_words.pop_front();
        words_checked++;
        check_field("kind", 64'(i_kind), 64'(want.kind));
        check_field("out_byte", 64'(i_out_byte), 64'(want.data));
        check_field("packet_first", 64'(i_packet_first), 64'(want.pkt_first));
        check_field("packet_last", 64'(i_packet_last), 64'(want.pkt_last));
        check_field("frame_index", 64'(i_frame_index), 64'(want.fidx));
        check_field("frame_number", 64'(i_frame_number), 64'(want.fnum));
        check_field("timestamp", 64'(i_timestamp), 64'(want.ts));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_ts    = 33'd0;
            ts_step     = 16'd3600;
            loop_lim    = 17'd0;
            parse_at    = wbsf_pkg::PH_HDR0;
            hdr_a       = 8'd0;
            hdr_b       = 8'd0;
            bytes_left  = 7'd0;
            frame_len   = 7'd0;
            frames_left = 3'd0;
            frame_pos   = 2'd0;
            pkt_count   = 32'd0;
            ts_now      = 33'd0;
            loops_done  = 16'd0;
            due_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wbsf_pkg::CFG_START_TS: begin
                        start_ts = i_cfg_data[32:0];
                        ts_now   = start_ts;
                    end
                    wbsf_pkg::CFG_TS_STEP:  ts_step  = i_cfg_data[15:0];
                    wbsf_pkg::CFG_LOOP_LIM: loop_lim = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) split_word(i_cmd, i_stream_byte);
            if (i_out_valid && !i_out_stall) check_word();
        end
        o_fail_count <= mismatches;
        o_pending    <= due_words.size();
        o_checked    <= words_checked;
    end

endmodule

// ----- tb/tb_amr_wbplus_superframe_splitter_core.sv -----
// Top of the superframe splitter testbench: clock, reset, stream stimulus, register
// settings and output stalls. Instantiates amr_wbplus_superframe_splitter_core and
// wbsf_splitter_checker; uses wbsf_pkg.
module tb_amr_wbplus_superframe_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLDOFF_LEN  = 150;
    localparam int          NO_CAP       = 1000;
    localparam logic [32:0] LOOP_FOREVER = 33'h1FFFF;   // -1 in 17 bits
    localparam logic [32:0] LOOP_MOST_NEG = 33'h10000;  // -65536 in 17 bits

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_cmd;
    logic [7:0]  i_stream_byte;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [wbsf_pkg::CFG_WIDTH-1:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic        o_packet_first;
    logic        o_packet_last;
    logic [1:0]  o_frame_index;
    logic [31:0] o_frame_number;
    logic [32:0] o_timestamp;

    int fail_count;
    int pending;
    int checked;
    int words_sent  = 0;
    int cycle_count = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit holdoff_go  = 1'b0;

    amr_wbplus_superframe_splitter_core uut (.*);

    wbsf_splitter_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_cmd          (i_cmd),
        .i_stream_byte  (i_stream_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_kind         (o_kind),
        .i_out_byte     (o_out_byte),
        .i_packet_first (o_packet_first),
        .i_packet_last  (o_packet_last),
        .i_frame_index  (o_frame_index),
        .i_frame_number (o_frame_number),
        .i_timestamp    (o_timestamp),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // output stalls, with one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_go && !hold_used) begin
                hold_left = HOLDOFF_LEN;
                hold_used = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // cut_at < 0 sends the whole superframe, otherwise end of stream after cut_at % size
    // bytes; room caps the words sent so a phase stays near its budget
    task automatic send_superframe(input logic [6:0] ft, input logic [7:0] second,
                                   input int cut_at, input int room);
        int total;
        int cut;
        total = int'(wbsf_pkg::frame_size(ft)) *
                ((ft <= 7'd9 || ft == 7'd14 || ft == 7'd15) ? 1 : 4);
        cut = (cut_at < 0 || total == 0) ? total : cut_at % total;
        if (cut + 2 > room) cut = (room > 3) ? room - 3 : 0;
        send_word(1'b0, {1'($urandom), ft});
        send_word(1'b0, second);
        for (int k = 0; k < cut; k++) send_word(1'b0, 8'($urandom));
        if (cut < total) send_word(1'b1, 8'($urandom));
    endtask

    task automatic run_random(input int goal);
        int         pick;
        int         k;
        int         cut_at;
        logic [6:0] ft;
        while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                if ($urandom_range(99) < 20) begin
                    ft = 7'($urandom_range(47, 16));
                end else begin
                    k  = $urandom_range(11);
                    ft = (k < 10) ? 7'(k) : 7'(k + 4);
                end
                cut_at = ($urandom_range(99) < 25) ? int'($urandom_range(400)) : -1;
                send_superframe(ft, {3'($urandom), 5'($urandom_range(13))}, cut_at,
                                goal - words_sent);
            end else if (pick < 78) begin
                send_word(1'b1, 8'($urandom));
            end else if (pick < 90) begin
                if ($urandom_range(1) == 1) begin
                    send_word(1'b0, {1'($urandom), 7'($urandom_range(127, 48))});
                    send_word(1'b0, 8'($urandom));
                end else begin
                    send_word(1'b0, {1'($urandom), 7'($urandom_range(47))});
                    send_word(1'b0, {3'($urandom), 5'($urandom_range(31, 14))});
                end
            end else begin
                // stray bytes, then end of stream to get back in step
                repeat ($urandom_range(3, 1)) send_word(1'b0, 8'($urandom));
                send_word(1'b1, 8'($urandom));
            end
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [32:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted word has come out
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cmd         <= 1'b0;
        i_stream_byte <= 8'h00;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= wbsf_pkg::CFG_START_TS;
        i_cfg_data    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, register values from reset
        send_superframe(7'd14, 8'h0D, -1, NO_CAP);   // empty frame, highest valid ISF
        send_word(1'b0, 8'h8F);                      // empty frame, TFI bits set
        send_word(1'b0, 8'hC0);
        send_superframe(7'd9, 8'hE5, -1, NO_CAP);    // short single frame
        send_word(1'b0, 8'h30);                      // first bad frame type
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);                      // worst frame type and ISF
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);                      // first bad ISF
        send_word(1'b0, 8'h0E);
        send_word(1'b1, 8'hFF);                      // end marker, no replays allowed
        send_superframe(7'd47, 8'h00, 3, NO_CAP);    // largest type, cut short
        send_word(1'b0, 8'h10);                      // end between header bytes
        send_word(1'b1, 8'h00);
        settle();

        // no idling, wrapping timestamps, endless replay, long output hold-off
        cfg_write(wbsf_pkg::CFG_START_TS, 33'h1FFFFFFFF);
        cfg_write(wbsf_pkg::CFG_TS_STEP, 33'd65535);
        cfg_write(wbsf_pkg::CFG_LOOP_LIM, LOOP_FOREVER);
        holdoff_go = 1'b1;
        // four-frame type, cut inside the second frame after its header replay
        send_superframe(7'd16, 8'h03, 30, NO_CAP);
        run_random(words_sent + 25);
        settle();

        // sender idles
        cfg_write(wbsf_pkg::CFG_START_TS, 33'd0);
        cfg_write(wbsf_pkg::CFG_TS_STEP, 33'd0);
        cfg_write(wbsf_pkg::CFG_LOOP_LIM, 33'd65535);
        gap_pct = 59;
        run_random(words_sent + 25);
        settle();

        // receiver stalls
        cfg_write(wbsf_pkg::CFG_START_TS, {1'($urandom), 32'($urandom)});
        cfg_write(wbsf_pkg::CFG_TS_STEP, 33'($urandom_range(65535)));
        cfg_write(wbsf_pkg::CFG_LOOP_LIM, 33'd2);
        gap_pct   = 0;
        stall_pct = 59;
        run_random(words_sent + 25);
        settle();

        // both sides idle
        cfg_write(wbsf_pkg::CFG_START_TS, {1'($urandom), 32'($urandom)});
        cfg_write(wbsf_pkg::CFG_TS_STEP, 33'd1);
        cfg_write(wbsf_pkg::CFG_LOOP_LIM, LOOP_MOST_NEG);
        gap_pct   = 23;
        stall_pct = 23;
        run_random(words_sent + 25);
        settle();

        $display("stream words sent: %0d, output words checked: %0d", words_sent, checked);
        $display("five register settings, four idle profiles and one long output hold-off");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
